// ===== rtl/core/hsd_pkg.sv =====
package hsd_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    // child index 2*pos+2 needs two bits beyond the address
    localparam int CH_W         = ADDR_W + 2;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_BLD_NEXT,
        ST_BLD_LOAD,
        ST_EXT_NEXT,
        ST_EXT_ROOT,
        ST_EXT_LAST,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_SIFT_C,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } t_state;

    typedef enum logic [2:0] {
        RD_KM1,
        RD_ZERO,
        RD_LEFT,
        RD_RIGHT,
        RD_K
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_IN,
        WR_ROOT,
        WR_CHILD,
        WR_CUR
    } t_wr_sel;

    typedef enum logic [2:0] {
        K_HOLD,
        K_LEN,
        K_ZERO,
        K_DEC,
        K_INC
    } t_k_op;

    typedef struct packed {
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_k_op   k_op;
        logic    cnt_inc;    // count one stored input value
        logic    cnt_clr;
        logic    len_load;   // last item: latch set size, k = size/2
        logic    pos_km1;    // build: pos = k-1, heap size = len
        logic    pos_root;   // extract: pos = 0, heap size = k-1
        logic    pos_child;
        logic    cur_load;
        logic    child_load;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic k_zero;
        logic k_le1;
        logic left_out;   // no left child inside the heap
        logic cand_less;  // smaller child is below the sifted value
        logic out_final;
    } t_dp_sts;

endpackage

// ===== rtl/core/hsd_ram.sv =====
module hsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hsd_datapath.sv =====
module hsd_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hsd_pkg::t_dp_cmd             i_cmd,
    input  logic signed [hsd_pkg::DATA_W-1:0] i_value,
    output hsd_pkg::t_dp_sts             o_sts,
    output logic signed [hsd_pkg::DATA_W-1:0] o_value,
    output logic                         o_final
);
    import hsd_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_len;
    logic [CNT_W-1:0]         r_k;
    logic [CNT_W-1:0]         r_slen;
    logic [ADDR_W-1:0]        r_pos;
    logic [ADDR_W-1:0]        r_cidx;
    logic signed [DATA_W-1:0] r_cur;
    logic signed [DATA_W-1:0] r_child;
    logic signed [DATA_W-1:0] r_out;
    logic                     r_final;

    logic [CNT_W-1:0]         n_len;
    logic [CNT_W-1:0]         w_km1;
    logic [CH_W-1:0]          w_left;
    logic [CH_W-1:0]          w_right;
    logic signed [DATA_W-1:0] w_rdata;
    logic                     w_right_less;
    logic signed [DATA_W-1:0] w_cand;
    logic [ADDR_W-1:0]        w_cand_idx;
    logic                     w_full;

    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic [DATA_W-1:0]        w_wdata;
    logic [ADDR_W-1:0]        w_raddr;
    logic [DATA_W-1:0]        w_ram_q;

    assign w_full   = (r_count == CNT_W'(MAX_ELEMENTS));
    assign n_len    = w_full ? r_count : r_count + CNT_W'(1);
    assign w_km1    = r_k - CNT_W'(1);
    assign w_left   = {1'b0, r_pos, 1'b1};
    assign w_right  = w_left + CH_W'(1);
    assign w_rdata  = $signed(w_ram_q);

    // pick the smaller child; left wins ties
    assign w_right_less = (w_right < CH_W'(r_slen)) && (w_rdata < r_child);
    assign w_cand       = w_right_less ? w_rdata : r_child;
    assign w_cand_idx   = w_right_less ? w_right[ADDR_W-1:0] : r_cidx;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_KM1:   w_raddr = w_km1[ADDR_W-1:0];
            RD_ZERO:  w_raddr = '0;
            RD_LEFT:  w_raddr = w_left[ADDR_W-1:0];
            RD_RIGHT: w_raddr = w_right[ADDR_W-1:0];
            RD_K:     w_raddr = r_k[ADDR_W-1:0];
            default:  w_raddr = '0;
        endcase
    end

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_pos;
        w_wdata = r_cur;
        case (i_cmd.wr_sel)
            WR_IN: begin
                w_waddr = r_count[ADDR_W-1:0];
                w_wdata = i_value;
            end
            WR_ROOT: begin
                w_waddr = w_km1[ADDR_W-1:0];
                w_wdata = r_child;
            end
            WR_CHILD: w_wdata = w_cand;
            WR_CUR:   w_wdata = r_cur;
            default:  w_we = 1'b0;
        endcase
    end

    hsd_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.len_load) begin
            r_len <= n_len;
            r_k   <= n_len >> 1;
        end else begin
            case (i_cmd.k_op)
                K_LEN:   r_k <= r_len;
                K_ZERO:  r_k <= '0;
                K_DEC:   r_k <= w_km1;
                K_INC:   r_k <= r_k + CNT_W'(1);
                default: r_k <= r_k;
            endcase
        end
        if (i_cmd.pos_km1) begin
            r_pos  <= w_km1[ADDR_W-1:0];
            r_slen <= r_len;
        end else if (i_cmd.pos_root) begin
            r_pos  <= '0;
            r_slen <= w_km1;
        end else if (i_cmd.pos_child) begin
            r_pos  <= w_cand_idx;
        end
        if (i_cmd.cur_load) begin
            r_cur <= w_rdata;
        end
        if (i_cmd.child_load) begin
            r_child <= w_rdata;
            r_cidx  <= w_left[ADDR_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out   <= w_rdata;
            r_final <= ((r_k + CNT_W'(1)) == r_len);
        end
    end

    assign o_sts.full      = w_full;
    assign o_sts.k_zero    = (r_k == '0);
    assign o_sts.k_le1     = (r_k <= CNT_W'(1));
    assign o_sts.left_out  = (w_left >= CH_W'(r_slen));
    assign o_sts.cand_less = (w_cand < r_cur);
    assign o_sts.out_final = r_final;

    assign o_value = r_out;
    assign o_final = r_final;

endmodule

// ===== rtl/core/hsd_ctrl.sv =====
module hsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tlast,
    input  logic              i_m_tready,
    input  hsd_pkg::t_dp_sts  i_sts,
    output hsd_pkg::t_dp_cmd  o_cmd,
    output logic              o_s_tready,
    output logic              o_m_tvalid
);
    import hsd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_extract;
    logic   n_extract;
    t_state w_ret;

    assign w_ret = r_extract ? ST_EXT_NEXT : ST_BLD_NEXT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_extract <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_extract <= n_extract;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_extract  = r_extract;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_ZERO;
        o_cmd.wr_sel = WR_NONE;
        o_cmd.k_op   = K_HOLD;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (!i_sts.full) begin
                        o_cmd.wr_sel  = WR_IN;
                        o_cmd.cnt_inc = 1'b1;
                    end
                    if (i_s_tlast) begin
                        o_cmd.len_load = 1'b1;
                        n_extract      = 1'b0;
                        n_state        = ST_BLD_NEXT;
                    end
                end
            end
            ST_BLD_NEXT: begin
                if (i_sts.k_zero) begin
                    o_cmd.k_op = K_LEN;
                    n_extract  = 1'b1;
                    n_state    = ST_EXT_NEXT;
                end else begin
                    o_cmd.rd_sel  = RD_KM1;
                    o_cmd.pos_km1 = 1'b1;
                    o_cmd.k_op    = K_DEC;
                    n_state       = ST_BLD_LOAD;
                end
            end
            ST_BLD_LOAD: begin
                o_cmd.cur_load = 1'b1;
                n_state        = ST_SIFT_L;
            end
            ST_EXT_NEXT: begin
                if (i_sts.k_le1) begin
                    o_cmd.k_op = K_ZERO;
                    n_state    = ST_EMIT_RD;
                end else begin
                    o_cmd.rd_sel = RD_ZERO;
                    n_state      = ST_EXT_ROOT;
                end
            end
            ST_EXT_ROOT: begin
                o_cmd.child_load = 1'b1;
                o_cmd.rd_sel     = RD_KM1;
                n_state          = ST_EXT_LAST;
            end
            ST_EXT_LAST: begin
                o_cmd.cur_load = 1'b1;
                o_cmd.wr_sel   = WR_ROOT;
                o_cmd.pos_root = 1'b1;
                o_cmd.k_op     = K_DEC;
                n_state        = ST_SIFT_L;
            end
            ST_SIFT_L: begin
                if (i_sts.left_out) begin
                    o_cmd.wr_sel = WR_CUR;
                    n_state      = w_ret;
                end else begin
                    o_cmd.rd_sel = RD_LEFT;
                    n_state      = ST_SIFT_R;
                end
            end
            ST_SIFT_R: begin
                o_cmd.child_load = 1'b1;
                o_cmd.rd_sel     = RD_RIGHT;
                n_state          = ST_SIFT_C;
            end
            ST_SIFT_C: begin
                if (i_sts.cand_less) begin
                    o_cmd.wr_sel    = WR_CHILD;
                    o_cmd.pos_child = 1'b1;
                    n_state         = ST_SIFT_L;
                end else begin
                    o_cmd.wr_sel = WR_CUR;
                    n_state      = w_ret;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.rd_sel = RD_K;
                n_state      = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    if (i_sts.out_final) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_COLLECT;
                    end else begin
                        o_cmd.k_op = K_INC;
                        n_state    = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

endmodule

// ===== rtl/core/heap_sort_descending.sv =====
// Heap sort, descending. Signed 32-bit values stream in on the slave side,
// one per transfer, and are stored in a 64-entry single-port-read RAM;
// collecting costs one cycle per value. The transfer with tlast set closes
// the set (values past 64 are dropped, but a tlast on a dropped value still
// closes the set). The block then stops accepting input, builds a min-heap in
// place, repeatedly moves the root to the end of the heap and sifts down,
// leaving the store in descending order, and streams it out largest first
// with tlast on the smallest value. After that transfer a new set begins.
// Each sift-down level is a left child read, a right child read, and a
// compare and write back, since the RAM gives one registered read per cycle;
// a sift that reaches a leaf ends with a leaf check that writes the value
// back. A sift is set up in ST_BLD_NEXT and ST_BLD_LOAD (build) or in
// ST_EXT_NEXT, ST_EXT_ROOT and ST_EXT_LAST (extract). A set of n values
// takes n/2 build sifts and n-1 extract sifts of up to log2(n) levels. Each
// output is read, registered, then offered until the master side takes it.
module heap_sort_descending (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    input  logic        s_tlast,   // last of set
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value (signed)
    output logic        m_tlast    // final_res
);
    import hsd_pkg::*;

    t_dp_cmd                  w_cmd;
    t_dp_sts                  w_sts;
    logic signed [DATA_W-1:0] w_out_value;

    hsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tlast  (s_tlast),
        .i_m_tready (m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid)
    );

    hsd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value ($signed(s_tdata)),
        .o_sts   (w_sts),
        .o_value (w_out_value),
        .o_final (m_tlast)
    );

    assign m_tdata = w_out_value;

    // input and output never open at the same time
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // closing transfer stops input for the sort
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after end of set");

    // final result hands control back to collection
    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("no return to collection after final result");

    // store count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.full |-> !w_cmd.cnt_inc)
        else $error("store written while full");

endmodule

// ===== verif/heap_sort_descending_test.sv =====
`timescale 1ns / 100ps

module heap_sort_descending_test;
    import hsd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;  // slowest legal run is far below this
    localparam int DRAIN_CYCLES = 100;     // quiet window after the last output
    localparam int ITEM_TARGET  = 400;     // stored values in the random part

    // one slave-side transfer, plus the idle cycles the driver waits before it
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic [3:0]        gap;
    } t_pending;

    // one predicted master-side transfer
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              final_flag;
    } t_sorted;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;     // [31:0] value (signed)
    logic              s_tlast  = 1'b0;   // last of set
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;           // [31:0] sorted_value (signed)
    logic              m_tlast;           // final_res

    heap_sort_descending uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // stimulus waiting for the driver, values of the open set, predicted outputs
    t_pending          pending_items[$];
    logic [DATA_W-1:0] open_set[$];
    t_sorted           sorted_expect[$];

    int unsigned err_count      = 0;
    int unsigned values_stored  = 0;
    int unsigned values_dropped = 0;
    int unsigned sets_closed    = 0;
    int unsigned full_sets      = 0;
    int unsigned outputs_seen   = 0;
    int unsigned items_queued   = 0;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Closing a set: order it largest first (signed), tag the smallest as final.
    task automatic close_set();
        int                n;
        int                i;
        int                j;
        logic [DATA_W-1:0] key;
        n = open_set.size();
        for (i = 1; i < n; i++) begin
            key = open_set[i];
            j = i - 1;
            while (j >= 0 && $signed(open_set[j]) < $signed(key)) begin
                open_set[j + 1] = open_set[j];
                j--;
            end
            open_set[j + 1] = key;
        end
        for (i = 0; i < n; i++) begin
            sorted_expect.push_back('{value: open_set[i], final_flag: (i == n - 1)});
        end
        sets_closed++;
        if (n == MAX_ELEMENTS) begin
            full_sets++;
        end
        open_set.delete();
    endtask

    // Every accepted input transfer goes through here.
    task automatic absorb_value(input logic [DATA_W-1:0] v, input logic last);
        if (open_set.size() < MAX_ELEMENTS) begin
            open_set.push_back(v);
            values_stored++;
        end else begin
            values_dropped++;   // store full: value is lost, tlast still counts
        end
        if (last) begin
            close_set();
        end
    endtask

    // ---------------------------------------------------------------- driver
    // Presents pending items in order; each one first waits out its own gap.
    logic        drv_loaded = 1'b0;
    int unsigned drv_wait   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid   <= 1'b0;
            drv_loaded = 1'b0;
            drv_wait   = 0;
        end else begin
            if (drv_loaded && s_tready) begin
                absorb_value(s_tdata, s_tlast);
                drv_loaded = 1'b0;
            end
            if (!drv_loaded && pending_items.size() > 0 &&
                    drv_wait >= pending_items[0].gap) begin
                s_tdata    <= pending_items[0].value;
                s_tlast    <= pending_items[0].last;
                s_tvalid   <= 1'b1;
                void'(pending_items.pop_front());
                drv_loaded = 1'b1;
                drv_wait   = 0;
            end else if (!drv_loaded) begin
                s_tvalid <= 1'b0;
                if (pending_items.size() > 0) begin
                    drv_wait++;
                end
            end
        end
    end

    // --------------------------------------------------------------- monitor
    // Checks each output transfer, then holds tready low for a random stall.
    // Now and then a stretch of back-to-back acceptance is inserted.
    int unsigned rdy_wait  = 0;
    int unsigned rdy_gap   = 0;
    int unsigned calm_left = 0;
    t_sorted     want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rdy_wait = 0;
            rdy_gap  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sorted_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected output %0d (tlast %0b)",
                                              $signed(m_tdata), m_tlast));
                end else begin
                    want = sorted_expect.pop_front();
                    outputs_seen++;
                    if (m_tdata !== want.value) begin
                        report_mismatch($sformatf("output %0d: value %0d, expected %0d",
                                                  outputs_seen, $signed(m_tdata),
                                                  $signed(want.value)));
                    end
                    if (m_tlast !== want.final_flag) begin
                        report_mismatch($sformatf("output %0d: tlast %0b, expected %0b",
                                                  outputs_seen, m_tlast, want.final_flag));
                    end
                end
                rdy_wait = 0;
                if (calm_left > 0) begin
                    calm_left--;
                    rdy_gap = 0;
                end else begin
                    rdy_gap = $urandom_range(0, 8);
                    if ($urandom_range(0, 15) == 0) begin
                        calm_left = $urandom_range(10, 40);
                    end
                end
            end
            if (rdy_wait >= rdy_gap) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rdy_wait++;
            end
        end
    end

    // ------------------------------------------------------------- stimulus
    function automatic logic [DATA_W-1:0] random_value();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel < 4) begin
            return $urandom;
        end else if (sel < 6) begin
            return $urandom_range(0, 16) - 32'd8;   // narrow range, many repeats
        end else begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h8000_0001;
                default: return 32'h7FFF_FFFE;
            endcase
        end
    endfunction

    task automatic add_item(input logic [DATA_W-1:0] v, input logic last, input bit calm);
        logic [3:0] gap;
        gap = calm ? 4'd0 : 4'($urandom_range(0, 8));
        pending_items.push_back('{value: v, last: last, gap: gap});
    endtask

    // random content; tlast on the final item, which is dropped when len > capacity
    task automatic queue_set(input int len, input bit calm);
        int i;
        for (i = 0; i < len; i++) begin
            add_item(random_value(), i == len - 1, calm);
            if (i < MAX_ELEMENTS) begin
                items_queued++;
            end
        end
    endtask

    initial begin
        int unsigned pick;
        int          set_len;
        int          i;

        // single-value set
        add_item(32'h8000_0000, 1'b1, 1'b0);
        // field extremes, mixed signs, repeats
        add_item(32'h7FFF_FFFF, 1'b0, 1'b0);
        add_item(32'h8000_0000, 1'b0, 1'b0);
        add_item(32'h0000_0000, 1'b0, 1'b0);
        add_item(32'hFFFF_FFFF, 1'b0, 1'b0);
        add_item(32'h0000_0001, 1'b0, 1'b0);
        add_item(32'h7FFF_FFFF, 1'b0, 1'b0);
        add_item(32'h8000_0000, 1'b0, 1'b0);
        add_item(32'h5555_5555, 1'b0, 1'b0);
        add_item(32'hAAAA_AAAA, 1'b1, 1'b0);
        // all values equal
        for (i = 0; i < 4; i++) begin
            add_item(32'hFFFF_FFF9, i == 3, 1'b1);
        end
        // already ascending input
        for (i = 0; i < 6; i++) begin
            add_item(32'(i * 3 - 7), i == 5, 1'b0);
        end
        // two values
        add_item(32'h0000_0000, 1'b0, 1'b1);
        add_item(32'h8000_0001, 1'b1, 1'b1);

        // a full store, then an overrun whose tlast lands on a dropped value
        queue_set(MAX_ELEMENTS, 1'b0);
        queue_set(MAX_ELEMENTS + 5, 1'b1);
        // random sets, mostly small
        while (items_queued < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                set_len = $urandom_range(1, 8);
            end else if (pick < 85) begin
                set_len = $urandom_range(9, 40);
            end else if (pick < 95) begin
                set_len = MAX_ELEMENTS;
            end else begin
                set_len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 6);
            end
            queue_set(set_len, $urandom_range(0, 3) == 0);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // poll on the falling edge, clear of the clocked processes
        while ((pending_items.size() != 0 || drv_loaded || sorted_expect.size() != 0) &&
                cycle_count < CYCLE_LIMIT) begin
            @(negedge i_clk);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d outputs still pending",
                     cycle_count, sorted_expect.size());
            $display("Simulation FAILED");
        end else begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            if (sorted_expect.size() != 0) begin
                report_mismatch($sformatf("%0d outputs never arrived", sorted_expect.size()));
            end
            $display("Sorted %0d sets (%0d filled to capacity) from %0d stored values, %0d dropped",
                     sets_closed, full_sets, values_stored, values_dropped);
            $display("Compared %0d outputs in descending order, %0d mismatches",
                     outputs_seen, err_count);
            if (err_count == 0) begin
                $display("Simulation PASSED");
            end else begin
                $display("Simulation FAILED");
            end
        end
        $finish;
    end

endmodule
